// ----- hdl/pwmr_pkg.sv -----
// Shared types and constants of the pulse-width Manchester receiver.
package pwmr_pkg;

    localparam int WIDTH_W    = 17;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int STATUS_W   = 2;
    localparam int FRAME_OUT_W = 56;
    localparam int SYNC_W     = 3;

    typedef logic [WIDTH_W-1:0] width_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_HW_SYNC_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HW_SYNC_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SW_SYNC_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SW_SYNC_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HALF_SYM_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HALF_SYM_MAX = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SYM_MIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SYM_MAX = 3'd7;

    // Window bounds after reset
    localparam width_t RST_HW_SYNC_MIN  = 17'd1691;
    localparam width_t RST_HW_SYNC_MAX  = 17'd3140;
    localparam width_t RST_SW_SYNC_MIN  = 17'd3185;
    localparam width_t RST_SW_SYNC_MAX  = 17'd5915;
    localparam width_t RST_HALF_SYM_MIN = 17'd422;
    localparam width_t RST_HALF_SYM_MAX = 17'd785;
    localparam width_t RST_FULL_SYM_MIN = 17'd845;
    localparam width_t RST_FULL_SYM_MAX = 17'd1570;

    // Receiver status codes
    localparam status_t ST_WAIT = 2'd0;
    localparam status_t ST_RECV = 2'd1;
    localparam status_t ST_DONE = 2'd2;

    localparam logic [SYNC_W-1:0] SYNC_SAT = 3'd7;

    typedef struct packed {
        width_t hw_sync_min;
        width_t hw_sync_max;
        width_t sw_sync_min;
        width_t sw_sync_max;
        width_t half_sym_min;
        width_t half_sym_max;
        width_t full_sym_min;
        width_t full_sym_max;
    } win_bounds_t;

    typedef struct packed {
        logic hw_sync;
        logic sw_sync;
        logic half_sym;
        logic full_sym;
    } win_hits_t;

endpackage

// ----- hdl/pwmr_classify.sv -----
// Pulse width classifier: open-window compares against the programmed bounds.
module pwmr_classify (
    input  pwmr_pkg::width_t      pulse_width,
    input  pwmr_pkg::win_bounds_t bounds,
    output pwmr_pkg::win_hits_t   hits
);
    import pwmr_pkg::*;

    always_comb begin
        hits.hw_sync  = (pulse_width > bounds.hw_sync_min) &&
                        (pulse_width < bounds.hw_sync_max);
        hits.sw_sync  = (pulse_width > bounds.sw_sync_min) &&
                        (pulse_width < bounds.sw_sync_max);
        hits.half_sym = (pulse_width > bounds.half_sym_min) &&
                        (pulse_width < bounds.half_sym_max);
        hits.full_sym = (pulse_width > bounds.full_sym_min) &&
                        (pulse_width < bounds.full_sym_max);
    end

endmodule

// ----- hdl/pwmr_frame.sv -----
// Frame tracker: sync counting, bit assembly and result for one pulse.
module pwmr_frame #(
    parameter int FRAME_BITS      = 56,
    parameter int MIN_SYNC_PULSES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  pwmr_pkg::win_hits_t                 hits,
    output pwmr_pkg::status_t                   res_status,
    output logic [pwmr_pkg::FRAME_OUT_W-1:0]    res_frame
);
    import pwmr_pkg::*;

    localparam int BIT_W = $clog2(FRAME_BITS + 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(FRAME_BITS);
    localparam logic [SYNC_W-1:0] SYNC_MIN = SYNC_W'(MIN_SYNC_PULSES);

    logic                  recv_reg,   recv_next;
    logic [SYNC_W-1:0]     sync_reg,   sync_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic                  last_reg,   last_next;
    logic                  half_reg,   half_next;
    logic [FRAME_BITS-1:0] frame_reg,  frame_next;
    logic [FRAME_BITS-1:0] set_mask;
    logic [FRAME_BITS-1:0] frame_res;
    logic                  append;

    // One-hot position of the next bit, first bit at the top
    always_comb begin
        for (int i = 0; i < FRAME_BITS; i++) begin
            set_mask[i] = (bit_cnt_reg == BIT_W'(FRAME_BITS - 1 - i));
        end
    end

    always_comb begin
        recv_next    = recv_reg;
        sync_next    = sync_reg;
        bit_cnt_next = bit_cnt_reg;
        last_next    = last_reg;
        half_next    = half_reg;
        frame_next   = frame_reg;
        append       = 1'b0;
        res_status   = ST_WAIT;
        frame_res    = '0;

        if (!recv_reg) begin
            if (hits.hw_sync) begin
                if (sync_reg != SYNC_SAT) begin
                    sync_next = sync_reg + 1'b1;
                end
            end else if (hits.sw_sync && (sync_reg >= SYNC_MIN)) begin
                bit_cnt_next = '0;
                last_next    = 1'b0;
                half_next    = 1'b0;
                frame_next   = '0;
                recv_next    = 1'b1;
            end else begin
                sync_next = '0;
            end
        end else begin
            if (hits.full_sym && !half_reg) begin
                last_next = ~last_reg;
                append    = 1'b1;
            end else if (hits.half_sym) begin
                half_next = ~half_reg;
                append    = half_reg;
            end else begin
                sync_next = '0;
                recv_next = 1'b0;
            end
        end

        if (append && (bit_cnt_reg < BIT_LAST)) begin
            if (last_next) begin
                frame_next = frame_reg | set_mask;
            end
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end

        if (recv_next) begin
            res_status = ST_RECV;
            if (bit_cnt_next >= BIT_LAST) begin
                res_status = ST_DONE;
                recv_next  = 1'b0;
                frame_res  = frame_next;
            end
        end
    end

    generate
        if (FRAME_BITS >= FRAME_OUT_W) begin : g_trunc
            assign res_frame = frame_res[FRAME_OUT_W-1:0];
        end else begin : g_ext
            assign res_frame = {{(FRAME_OUT_W-FRAME_BITS){1'b0}}, frame_res};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recv_reg    <= 1'b0;
            sync_reg    <= '0;
            bit_cnt_reg <= '0;
            last_reg    <= 1'b0;
            half_reg    <= 1'b0;
            frame_reg   <= '0;
        end else if (step_en) begin
            recv_reg    <= recv_next;
            sync_reg    <= sync_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
            half_reg    <= half_next;
            frame_reg   <= frame_next;
        end
    end

endmodule

// ----- hdl/pulse_width_manchester_receiver.sv -----
// Pulse-width Manchester receiver top level: window registers, word staging, result.
//
// Usage:
//   s_ channel: one word per measured pulse, s_tdata[16:0] = pulse_width (us).
//   m_ channel: exactly one word per accepted pulse, in order.
//     m_tuser[1:0] = rx_status (0 waiting, 1 receiving, 2 frame complete),
//     m_tdata[55:0] = frame_bits, first bit at the top, zero unless complete.
//   cfg_ port: write the eight window bounds (min/max for hardware sync,
//     software sync, half symbol, full symbol) while no word is in flight.
// Timing: a pulse lands in the input register, is classified and applied to
//   the frame state, and its result is registered for m_ when the output is
//   free. One word per cycle is sustained while m_tready stays high; the
//   compare-and-update step between the input and the result register is
//   combinational.
// Reset: aresetn low loads the default windows, clears sync count and frame.
// Stall: with m_tready low the result register holds; one more word can wait
//   in the input register before s_tready drops.
module pulse_width_manchester_receiver #(
    parameter int FRAME_BITS      = 56,
    parameter int MIN_SYNC_PULSES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pwmr_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  logic [pwmr_pkg::WIDTH_W-1:0]        cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // [16:0] pulse_width
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // [55:0] frame_bits
    output logic [pwmr_pkg::STATUS_W-1:0]       m_tuser    // [1:0] rx_status
);
    import pwmr_pkg::*;

    win_bounds_t bounds_reg;
    width_t      pw_reg;
    logic        in_vld_reg;
    logic        out_vld_reg;
    status_t     status_reg;
    logic [FRAME_OUT_W-1:0] frame_out_reg;

    win_hits_t   hits;
    status_t     res_status;
    logic [FRAME_OUT_W-1:0] res_frame;
    logic        step_en;
    logic        in_fire;

    assign step_en  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step_en;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg.hw_sync_min  <= RST_HW_SYNC_MIN;
            bounds_reg.hw_sync_max  <= RST_HW_SYNC_MAX;
            bounds_reg.sw_sync_min  <= RST_SW_SYNC_MIN;
            bounds_reg.sw_sync_max  <= RST_SW_SYNC_MAX;
            bounds_reg.half_sym_min <= RST_HALF_SYM_MIN;
            bounds_reg.half_sym_max <= RST_HALF_SYM_MAX;
            bounds_reg.full_sym_min <= RST_FULL_SYM_MIN;
            bounds_reg.full_sym_max <= RST_FULL_SYM_MAX;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HW_SYNC_MIN:  bounds_reg.hw_sync_min  <= cfg_wdata;
                REG_HW_SYNC_MAX:  bounds_reg.hw_sync_max  <= cfg_wdata;
                REG_SW_SYNC_MIN:  bounds_reg.sw_sync_min  <= cfg_wdata;
                REG_SW_SYNC_MAX:  bounds_reg.sw_sync_max  <= cfg_wdata;
                REG_HALF_SYM_MIN: bounds_reg.half_sym_min <= cfg_wdata;
                REG_HALF_SYM_MAX: bounds_reg.half_sym_max <= cfg_wdata;
                REG_FULL_SYM_MIN: bounds_reg.full_sym_min <= cfg_wdata;
                REG_FULL_SYM_MAX: bounds_reg.full_sym_max <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_fire) begin
            in_vld_reg <= 1'b1;
        end else if (step_en) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pw_reg <= s_tdata[WIDTH_W-1:0];
        end
    end

    pwmr_classify u_classify (
        .pulse_width (pw_reg),
        .bounds      (bounds_reg),
        .hits        (hits)
    );

    pwmr_frame #(
        .FRAME_BITS      (FRAME_BITS),
        .MIN_SYNC_PULSES (MIN_SYNC_PULSES)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .hits       (hits),
        .res_status (res_status),
        .res_frame  (res_frame)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step_en) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            status_reg    <= res_status;
            frame_out_reg <= res_frame;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = frame_out_reg;

`ifndef SYNTHESIS
    a_frame_zero_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_DONE)) |-> (m_tdata == '0))
        else $error("frame bits nonzero on an incomplete result");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled while the pipeline has room");

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> (m_tvalid && (m_tuser <= ST_DONE)))
        else $error("processed pulse produced no valid result");

    a_result_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser) && $stable(m_tdata)))
        else $error("result changed while stalled");
`endif

endmodule
